FILE: rtl/serial_rtc_datetime_access_assert.svh
// Assertion macros for the serial clock-chip master checker.
`ifndef SERIAL_RTC_DATETIME_ACCESS_ASSERT_SVH
`define SERIAL_RTC_DATETIME_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRDA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRDA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/srda_pkg.sv
// Types, constants and BCD helper functions for the serial clock-chip master.
package srda_pkg;

    localparam int NUM_FIELDS = 7;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_IDLE = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_GET  = 2'd2;

    // Register addresses on the clock chip.
    localparam logic [7:0] ADDR_PROTECT = 8'h8E;
    localparam logic [7:0] ADDR_YEAR    = 8'h8C;
    localparam logic [7:0] ADDR_WEEKDAY = 8'h8A;
    localparam logic [7:0] ADDR_MONTH   = 8'h88;
    localparam logic [7:0] ADDR_DAY     = 8'h86;
    localparam logic [7:0] ADDR_HOUR    = 8'h84;
    localparam logic [7:0] ADDR_MINUTE  = 8'h82;
    localparam logic [7:0] ADDR_SECOND  = 8'h80;
    localparam logic [7:0] READ_FLAG    = 8'h01;

    // Write-protect register values.
    localparam logic [7:0] PROTECT_OFF = 8'h00;
    localparam logic [7:0] PROTECT_ON  = 8'h10;

    // Transaction framing.
    localparam logic [5:0] LAST_POS  = 6'd33;
    localparam logic [3:0] SET_SLOTS = 4'd9;
    localparam logic [3:0] GET_SLOTS = 4'd7;
    localparam logic [3:0] LAST_SET_SLOT = 4'd8;

    // Reciprocal of ten for narrow values: (v * 205) >> 11 equals v / 10 below 1024.
    localparam logic [7:0] RECIP_TEN = 8'd205;

    typedef enum logic [2:0] {
        KIND_IDLE = 3'b001,
        KIND_SET  = 3'b010,
        KIND_GET  = 3'b100
    } burst_kind_t;

    typedef logic [6:0] field_t;
    typedef logic [NUM_FIELDS-1:0][6:0] fields_t;
    typedef logic [NUM_FIELDS-1:0][7:0] bcd_fields_t;

    typedef struct packed {
        logic enable;
        logic clock;
        logic data_out;
        logic data_drive;
        logic busy;
    } pin_state_t;

    function automatic logic [7:0] field_addr(input logic [2:0] idx);
        logic [7:0] addr;
        case (idx)
            3'd0:    addr = ADDR_YEAR;
            3'd1:    addr = ADDR_WEEKDAY;
            3'd2:    addr = ADDR_MONTH;
            3'd3:    addr = ADDR_DAY;
            3'd4:    addr = ADDR_HOUR;
            3'd5:    addr = ADDR_MINUTE;
            default: addr = ADDR_SECOND;
        endcase
        return addr;
    endfunction

    // Binary to packed BCD, the tens digit kept to four bits.
    function automatic logic [7:0] make_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = v * RECIP_TEN;
        tens     = prod[14:11];
        tens_x10 = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
        units    = v - tens_x10;
        return {tens, units[3:0]};
    endfunction

    // Packed BCD to binary: tens from bits 6:4, units nibble added as is.
    function automatic field_t take_bcd(input logic [7:0] b);
        return {1'b0, b[6:4], 3'b000} + {3'b000, b[6:4], 1'b0} + {3'b000, b[3:0]};
    endfunction

endpackage

FILE: rtl/srda_engine.sv
// Burst sequencer: transaction position, shift registers and decoded read values.
module srda_engine
    import srda_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [1:0] command,
    input  logic       io_sample,
    input  logic [6:0] set_year,
    input  logic [2:0] set_weekday,
    input  logic [3:0] set_month,
    input  logic [4:0] set_day,
    input  logic [4:0] set_hour,
    input  logic [5:0] set_minute,
    input  logic [5:0] set_second,
    output pin_state_t pins,
    output fields_t    decoded
);

    burst_kind_t kind_reg, kind_next, kind_cur;
    logic [3:0]  slot_reg, slot_next, slot_cur, slot_prev;
    logic [5:0]  pos_reg, pos_next, pos_cur, pos_m1;
    logic [15:0] send_reg, send_next;
    logic [7:0]  recv_reg, recv_next;
    bcd_fields_t held_reg, held_next;
    fields_t     decoded_reg, decoded_next;
    logic        start;
    logic        is_get;
    logic [3:0]  bit_idx;
    logic [3:0]  limit;
    logic [15:0] frame;

    assign start = (kind_reg == KIND_IDLE) && ((command == CMD_SET) || (command == CMD_GET));
    assign kind_cur = start ? ((command == CMD_SET) ? KIND_SET : KIND_GET) : kind_reg;
    assign slot_cur = start ? 4'd0 : slot_reg;
    assign pos_cur  = start ? 6'd0 : pos_reg;
    assign is_get   = (kind_cur == KIND_GET);
    assign pos_m1   = pos_cur - 6'd1;
    assign bit_idx  = pos_m1[4:1];
    assign slot_prev = slot_cur - 4'd1;
    assign limit    = is_get ? GET_SLOTS : SET_SLOTS;

    // Frame for the current transaction: address in the low byte, data in the high byte.
    always_comb begin
        if (is_get) begin
            frame = {8'h00, field_addr(slot_cur[2:0]) | READ_FLAG};
        end else if (slot_cur == 4'd0) begin
            frame = {PROTECT_OFF, ADDR_PROTECT};
        end else if (slot_cur >= LAST_SET_SLOT) begin
            frame = {PROTECT_ON, ADDR_PROTECT};
        end else begin
            frame = {held_reg[slot_prev[2:0]], field_addr(slot_prev[2:0])};
        end
    end

    always_comb begin
        kind_next    = kind_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        held_next    = held_reg;
        decoded_next = decoded_reg;
        pins         = '0;

        if (start && (command == CMD_SET)) begin
            held_next[0] = make_bcd(set_year);
            held_next[1] = make_bcd({4'b0000, set_weekday});
            held_next[2] = make_bcd({3'b000, set_month});
            held_next[3] = make_bcd({2'b00, set_day});
            held_next[4] = make_bcd({2'b00, set_hour});
            held_next[5] = make_bcd({1'b0, set_minute});
            held_next[6] = make_bcd({1'b0, set_second});
        end

        if (kind_cur != KIND_IDLE) begin
            pins.busy = 1'b1;
            if (pos_cur == 6'd0) begin
                send_next   = frame;
                recv_next   = '0;
                pins.enable = 1'b1;
            end else if (pos_cur < LAST_POS) begin
                pins.enable = 1'b1;
                pins.clock  = pos_m1[0];
                if (is_get && bit_idx[3]) begin
                    // Sample ahead of the rising edge, LSB first.
                    if (!pos_m1[0]) begin
                        recv_next = {io_sample, recv_reg[7:1]};
                    end
                end else begin
                    pins.data_drive = 1'b1;
                    pins.data_out   = send_reg[bit_idx];
                end
            end else if (is_get) begin
                decoded_next[slot_cur[2:0]] = take_bcd(recv_reg);
            end

            if (pos_cur >= LAST_POS) begin
                pos_next = 6'd0;
                if ((slot_cur + 4'd1) >= limit) begin
                    kind_next = KIND_IDLE;
                    slot_next = 4'd0;
                end else begin
                    kind_next = kind_cur;
                    slot_next = slot_cur + 4'd1;
                end
            end else begin
                kind_next = kind_cur;
                slot_next = slot_cur;
                pos_next  = pos_cur + 6'd1;
            end
        end
    end

    assign decoded = decoded_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= KIND_IDLE;
            slot_reg    <= '0;
            pos_reg     <= '0;
            send_reg    <= '0;
            recv_reg    <= '0;
            held_reg    <= '0;
            decoded_reg <= '0;
        end else if (step) begin
            kind_reg    <= kind_next;
            slot_reg    <= slot_next;
            pos_reg     <= pos_next;
            send_reg    <= send_next;
            recv_reg    <= recv_next;
            held_reg    <= held_next;
            decoded_reg <= decoded_next;
        end
    end

endmodule

FILE: rtl/serial_rtc_datetime_access.sv
// Top level of the three-wire serial clock-chip master with its output register.
//
//  Channel  Direction  Handshake           Carries
//  s_       in         s_valid / s_ready   one bus tick: command, data pin sample, set values
//  m_       out        m_valid / m_ready   pin levels for that tick, busy flag, decoded values
//
// Every accepted transfer is one bus tick and yields exactly one result transfer.
// The sequencer updates on acceptance and the result is loaded into the output register
// at that same edge, so a new tick is taken every cycle while the output is free or drained.
// s_ready is low only while a result sits in the output register and m_ready is low.
// Reset is synchronous and active low; it returns the sequencer to idle and clears
// the decoded values, and no result is presented until the first tick is accepted.
module serial_rtc_datetime_access
    import srda_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic       s_io_sample,
    input  logic [6:0] s_set_year,
    input  logic [2:0] s_set_weekday,
    input  logic [3:0] s_set_month,
    input  logic [4:0] s_set_day,
    input  logic [4:0] s_set_hour,
    input  logic [5:0] s_set_minute,
    input  logic [5:0] s_set_second,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_enable_pin,
    output logic       m_clock_pin,
    output logic       m_data_out,
    output logic       m_data_drive,
    output logic       m_busy_res,
    output logic [6:0] m_read_year,
    output logic [6:0] m_read_weekday,
    output logic [6:0] m_read_month,
    output logic [6:0] m_read_day,
    output logic [6:0] m_read_hour,
    output logic [6:0] m_read_minute,
    output logic [6:0] m_read_second
);

    logic       accept;
    logic       m_valid_reg;
    pin_state_t pins_next;
    pin_state_t pins_reg;
    fields_t    decoded_next;
    fields_t    decoded_reg;

    // The output register is free when empty or when its contents leave this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The sequencer advances by one tick per accepted transfer and works out the
    // pin levels and decoded values for that tick in the same cycle.
    srda_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .command     (s_command),
        .io_sample   (s_io_sample),
        .set_year    (s_set_year),
        .set_weekday (s_set_weekday),
        .set_month   (s_set_month),
        .set_day     (s_set_day),
        .set_hour    (s_set_hour),
        .set_minute  (s_set_minute),
        .set_second  (s_set_second),
        .pins        (pins_next),
        .decoded     (decoded_next)
    );

    // Valid flag of the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload of the output register; loaded only when a tick is accepted.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pins_reg    <= pins_next;
            decoded_reg <= decoded_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_enable_pin   = pins_reg.enable;
    assign m_clock_pin    = pins_reg.clock;
    assign m_data_out     = pins_reg.data_out;
    assign m_data_drive   = pins_reg.data_drive;
    assign m_busy_res     = pins_reg.busy;
    assign m_read_year    = decoded_reg[0];
    assign m_read_weekday = decoded_reg[1];
    assign m_read_month   = decoded_reg[2];
    assign m_read_day     = decoded_reg[3];
    assign m_read_hour    = decoded_reg[4];
    assign m_read_minute  = decoded_reg[5];
    assign m_read_second  = decoded_reg[6];

endmodule

FILE: rtl/srda_checker.sv
// Port-level checker for the serial clock-chip master, bound to the top level.
`include "serial_rtc_datetime_access_assert.svh"

module srda_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_enable_pin,
    input logic       m_clock_pin,
    input logic       m_data_out,
    input logic       m_data_drive,
    input logic       m_busy_res
);

    logic       stalled;
    logic [4:0] held_lines;
    logic       released;
    logic       idle_shown;
    logic       bus_quiet;
    logic       clock_shown;
    logic       clock_framed;

    assign stalled      = m_valid && !m_ready;
    assign held_lines   = {m_valid, m_enable_pin, m_clock_pin, m_data_drive, m_busy_res};
    assign released     = m_valid && !m_data_drive;
    assign idle_shown   = m_valid && !m_busy_res;
    assign bus_quiet    = !m_enable_pin && !m_clock_pin && !m_data_drive;
    assign clock_shown  = m_valid && m_clock_pin;
    assign clock_framed = m_enable_pin && m_busy_res;

    // A stalled result stays valid and keeps its enable, clock, drive and busy levels.
    `SRDA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, stalled, $stable(held_lines), "result changed")

    // A released data line carries no level.
    `SRDA_ASSERT_NOW(a_released_low, aclk, aresetn, released, !m_data_out, "released line high")

    // Outside a burst every bus line is quiet.
    `SRDA_ASSERT_NOW(a_idle_quiet, aclk, aresetn, idle_shown, bus_quiet, "bus active while idle")

    // The serial clock only pulses inside an enabled transfer.
    `SRDA_ASSERT_NOW(a_clock_enabled, aclk, aresetn, clock_shown, clock_framed, "stray clock")

    // The input side is never held off while the output register is empty.
    `SRDA_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_valid, s_ready, "not ready while empty")

endmodule

bind serial_rtc_datetime_access srda_checker u_srda_checker (.*);
